FILE: hdl/clsu_pkg.sv
// Package for the C-like lexical scanner unit: token and scan-mode types,
// lexeme lookup functions and sizing constants.
// No dependencies; imported by clsu_step, c_like_lexical_scanner_unit and its testbench.
package clsu_pkg;

   localparam int POS_WIDTH       = 16;
   localparam int OUT_POS_WIDTH   = 16;
   localparam int MAX_KEYWORD_LEN = 8;
   localparam int WORD_BITS       = 8 * MAX_KEYWORD_LEN;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

   typedef enum logic [5:0] {
      TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_LBRACK, TK_RBRACK,
      TK_COMMA, TK_SEMI, TK_KW_IF, TK_KW_ELSE, TK_KW_FOR, TK_KW_WHILE,
      TK_KW_CONTINUE, TK_KW_BREAK, TK_KW_RETURN, TK_NOT, TK_INC, TK_DEC,
      TK_ASSIGN, TK_AND_AND, TK_OR_OR, TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH,
      TK_PERCENT, TK_LT, TK_LE, TK_GT, TK_GE, TK_EQ, TK_NE, TK_KW_INT,
      TK_KW_STRING, TK_KW_VOID, TK_KW_TRUE, TK_KW_FALSE, TK_INT_LIT,
      TK_STR_LIT, TK_IDENT, TK_END, TK_INVALID
   } token_kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_INT, MODE_IDENT, MODE_STR, MODE_STR_ESC,
      MODE_LINE_CMT, MODE_BLK_CMT, MODE_BLK_STAR, MODE_OP
   } scan_mode_type;

   typedef struct packed {
      scan_mode_type          mode;
      logic [7:0]             pending;
      logic [POS_WIDTH-1:0]   tstart;
      logic [POS_WIDTH-1:0]   pos;
      logic [WORD_BITS-1:0]   wbuf;
      logic [3:0]             wlen;
   } scan_state_type;

   typedef struct packed {
      token_kind_type           kind;
      logic [OUT_POS_WIDTH-1:0] start_pos;
      logic [OUT_POS_WIDTH-1:0] end_pos;
      logic                     last;
   } token_type;

   // Single-character lexemes; anything else is an invalid character.
   function automatic token_kind_type single_kind(input logic [7:0] c);
      token_kind_type k;
      case (c)
         "(":     k = TK_LPAREN;
         ")":     k = TK_RPAREN;
         "{":     k = TK_LBRACE;
         "}":     k = TK_RBRACE;
         "[":     k = TK_LBRACK;
         "]":     k = TK_RBRACK;
         ",":     k = TK_COMMA;
         ";":     k = TK_SEMI;
         "!":     k = TK_NOT;
         "=":     k = TK_ASSIGN;
         "+":     k = TK_PLUS;
         "-":     k = TK_MINUS;
         "*":     k = TK_STAR;
         "/":     k = TK_SLASH;
         "%":     k = TK_PERCENT;
         "<":     k = TK_LT;
         ">":     k = TK_GT;
         default: k = TK_INVALID;
      endcase
      return k;
   endfunction

   // Two-character operators; hit is low when the pair is not a lexeme.
   function automatic logic [6:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
      token_kind_type k;
      logic           hit;
      hit = 1'b1;
      case ({a, b})
         "++":    k = TK_INC;
         "--":    k = TK_DEC;
         "&&":    k = TK_AND_AND;
         "||":    k = TK_OR_OR;
         "<=":    k = TK_LE;
         ">=":    k = TK_GE;
         "==":    k = TK_EQ;
         "!=":    k = TK_NE;
         default: begin
            k   = TK_INVALID;
            hit = 1'b0;
         end
      endcase
      return {hit, k};
   endfunction

   // The word buffer holds the identifier bytes right-justified, so a
   // keyword matches when both its length and its packed text agree.
   function automatic token_kind_type word_kind(input logic [WORD_BITS-1:0] wbuf,
                                                input logic [3:0] wlen);
      token_kind_type k;
      k = TK_IDENT;
      if (wlen <= 4'(MAX_KEYWORD_LEN)) begin
         if (wlen == 4'd2 && wbuf == WORD_BITS'("if"))       k = TK_KW_IF;
         if (wlen == 4'd4 && wbuf == WORD_BITS'("else"))     k = TK_KW_ELSE;
         if (wlen == 4'd3 && wbuf == WORD_BITS'("for"))      k = TK_KW_FOR;
         if (wlen == 4'd5 && wbuf == WORD_BITS'("while"))    k = TK_KW_WHILE;
         if (wlen == 4'd8 && wbuf == WORD_BITS'("continue")) k = TK_KW_CONTINUE;
         if (wlen == 4'd5 && wbuf == WORD_BITS'("break"))    k = TK_KW_BREAK;
         if (wlen == 4'd6 && wbuf == WORD_BITS'("return"))   k = TK_KW_RETURN;
         if (wlen == 4'd3 && wbuf == WORD_BITS'("int"))      k = TK_KW_INT;
         if (wlen == 4'd6 && wbuf == WORD_BITS'("string"))   k = TK_KW_STRING;
         if (wlen == 4'd4 && wbuf == WORD_BITS'("void"))     k = TK_KW_VOID;
         if (wlen == 4'd4 && wbuf == WORD_BITS'("true"))     k = TK_KW_TRUE;
         if (wlen == 4'd5 && wbuf == WORD_BITS'("false"))    k = TK_KW_FALSE;
      end
      return k;
   endfunction

   function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] p);
      return (p == POS_MAX) ? POS_MAX : p + 1'b1;
   endfunction

   function automatic token_type mk_tok(input token_kind_type k,
                                        input logic [POS_WIDTH-1:0] s,
                                        input logic [POS_WIDTH-1:0] e);
      token_type t;
      t.kind      = k;
      t.start_pos = OUT_POS_WIDTH'(s);
      t.end_pos   = OUT_POS_WIDTH'(e);
      t.last      = 1'b0;
      return t;
   endfunction

endpackage

FILE: hdl/clsu_step.sv
// Next-state and token logic of the scanner for one character.
// Purely combinational; depends on clsu_pkg.
module clsu_step
   import clsu_pkg::*;
(
   input  scan_state_type cur,
   input  logic [7:0]     ch,
   output scan_state_type nxt,
   output token_type      tok0,
   output token_type      tok1,
   output logic [1:0]     tok_cnt
);

   logic                 c_space;
   logic                 c_digit;
   logic                 c_alpha;
   logic                 c_oplead;
   logic [POS_WIDTH-1:0] pos_inc;
   logic [POS_WIDTH-1:0] tstart_inc;
   logic [6:0]           pair_res;
   token_type            tok_v [2];
   logic [1:0]           n;
   logic                 do_start;

   assign c_space    = (ch == " ") || (ch inside {[8'd9:8'd13]});
   assign c_digit    = ch inside {["0":"9"]};
   assign c_alpha    = ch inside {["a":"z"], ["A":"Z"]};
   assign c_oplead   = ch inside {"!", "+", "-", "=", "&", "|", "<", ">", "/"};
   assign pos_inc    = sat_inc(cur.pos);
   assign tstart_inc = sat_inc(cur.tstart);
   assign pair_res   = pair_kind(cur.pending, ch);

   always_comb begin
      nxt      = cur;
      tok_v[0] = '0;
      tok_v[1] = '0;
      n        = 2'd0;
      do_start = 1'b0;
      if (ch == 8'd0) begin
         // End of source: flush the open token, then the end token.
         case (cur.mode)
            MODE_INT: begin
               tok_v[0] = mk_tok(TK_INT_LIT, cur.tstart, cur.pos);
               n = 2'd1;
            end
            MODE_IDENT: begin
               tok_v[0] = mk_tok(word_kind(cur.wbuf, cur.wlen), cur.tstart, cur.pos);
               n = 2'd1;
            end
            MODE_STR, MODE_STR_ESC: begin
               tok_v[0] = mk_tok(TK_STR_LIT, cur.tstart, cur.pos);
               n = 2'd1;
            end
            MODE_OP: begin
               tok_v[0] = mk_tok(single_kind(cur.pending), cur.tstart, tstart_inc);
               n = 2'd1;
            end
            default: ;
         endcase
         tok_v[n[0]] = mk_tok(TK_END, cur.pos, cur.pos);
         n           = n + 2'd1;
         nxt         = '0;
         nxt.mode    = MODE_IDLE;
      end else begin
         case (cur.mode)
            MODE_LINE_CMT: begin
               if (ch == "\n") nxt.mode = MODE_IDLE;
            end
            MODE_BLK_CMT: begin
               if (ch == "*") nxt.mode = MODE_BLK_STAR;
            end
            MODE_BLK_STAR: begin
               if (ch == "/") nxt.mode = MODE_IDLE;
               else if (ch != "*") nxt.mode = MODE_BLK_CMT;
            end
            MODE_STR: begin
               if (ch == "\"") begin
                  tok_v[0] = mk_tok(TK_STR_LIT, cur.tstart, pos_inc);
                  n        = 2'd1;
                  nxt.mode = MODE_IDLE;
               end else if (ch == "\\") begin
                  nxt.mode = MODE_STR_ESC;
               end
            end
            MODE_STR_ESC: nxt.mode = MODE_STR;
            MODE_INT: begin
               if (!c_digit) begin
                  tok_v[0] = mk_tok(TK_INT_LIT, cur.tstart, cur.pos);
                  n        = 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (c_alpha || c_digit || ch == "_") begin
                  nxt.wbuf = {cur.wbuf[WORD_BITS-9:0], ch};
                  if (cur.wlen != 4'd15) nxt.wlen = cur.wlen + 4'd1;
               end else begin
                  tok_v[0] = mk_tok(word_kind(cur.wbuf, cur.wlen), cur.tstart, cur.pos);
                  n        = 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_OP: begin
               if (cur.pending == "/" && ch == "/") begin
                  nxt.mode = MODE_LINE_CMT;
               end else if (cur.pending == "/" && ch == "*") begin
                  nxt.mode = MODE_BLK_CMT;
               end else if (pair_res[6]) begin
                  tok_v[0] = mk_tok(token_kind_type'(pair_res[5:0]), cur.tstart, pos_inc);
                  n        = 2'd1;
                  nxt.mode = MODE_IDLE;
               end else begin
                  tok_v[0] = mk_tok(single_kind(cur.pending), cur.tstart, tstart_inc);
                  n        = 2'd1;
                  do_start = 1'b1;
               end
            end
            default: do_start = 1'b1;
         endcase

         // A character that begins a new token, or stands alone as one.
         if (do_start) begin
            nxt.mode = MODE_IDLE;
            if (!c_space) begin
               nxt.tstart = cur.pos;
               if (c_digit) begin
                  nxt.mode = MODE_INT;
               end else if (c_alpha || ch == "_") begin
                  nxt.mode = MODE_IDENT;
                  nxt.wbuf = WORD_BITS'(ch);
                  nxt.wlen = 4'd1;
               end else if (ch == "\"") begin
                  nxt.mode = MODE_STR;
               end else if (c_oplead) begin
                  nxt.mode    = MODE_OP;
                  nxt.pending = ch;
               end else begin
                  tok_v[n[0]] = mk_tok(single_kind(ch), cur.pos, pos_inc);
                  n           = n + 2'd1;
               end
            end
         end
         nxt.pos = pos_inc;
      end
      if (n != 2'd0) tok_v[~n[0]].last = 1'b1;
   end

   assign tok0    = tok_v[0];
   assign tok1    = tok_v[1];
   assign tok_cnt = n;

endmodule

FILE: hdl/c_like_lexical_scanner_unit.sv
// Top level of the C-like lexical scanner unit; depends on clsu_pkg and clsu_step.
// A character word waits in the input register until the token queue has room; it is then
// scanned, and its tokens enter the queue, whose head stays on the rsp_ ports until taken.
// Throughput: one character per cycle while the token queue has two free slots; a character
// that closes a token and is itself a one-character token (or a 0 closing an open token)
// emits two, and the queue drains one per cycle. Reset empties it; the scanner goes idle.
module c_like_lexical_scanner_unit
   import clsu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_ch,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [5:0]               rsp_token_kind,
   output logic [OUT_POS_WIDTH-1:0] rsp_start_pos,
   output logic [OUT_POS_WIDTH-1:0] rsp_end_pos,
   output logic                     rsp_last_of_run
);

   // Input register: holds one character word until the scanner takes it.
   logic                in_valid_ff;
   logic                in_valid_in;
   logic [7:0]          in_ch_ff;

   // Scanner state, updated once per character. Reset and a character 0 both return it
   // to idle with offsets counting from zero.
   scan_state_type      state_ff;
   scan_state_type      state_in;

   // Token queue that serves as the result register. It is only written when it
   // has room for the two tokens a character may produce, so the scan stage never
   // has to hold a half-delivered character.
   token_type           q_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] head_ff;
   logic [QUEUE_AW-1:0] head_in;
   logic [QUEUE_AW-1:0] tail_ff;
   logic [QUEUE_AW-1:0] tail_in;
   logic [QUEUE_CW-1:0] count_ff;
   logic [QUEUE_CW-1:0] count_in;

   token_type           tok0;
   token_type           tok1;
   logic [1:0]          tok_cnt;
   logic                advance;
   logic                pop;
   token_type           head_tok;

   clsu_step u_step (
      .cur     (state_ff),
      .ch      (in_ch_ff),
      .nxt     (state_in),
      .tok0    (tok0),
      .tok1    (tok1),
      .tok_cnt (tok_cnt)
   );

   // The held character is scanned when the queue has two free slots; the input
   // register refills in the same cycle, so characters stream at one per cycle.
   assign advance     = in_valid_ff && (count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2));
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   assign head_tok        = q_ff[head_ff];
   assign rsp_valid       = (count_ff != '0);
   assign pop             = rsp_valid && rsp_ready;
   assign rsp_token_kind  = head_tok.kind;
   assign rsp_start_pos   = head_tok.start_pos;
   assign rsp_end_pos     = head_tok.end_pos;
   assign rsp_last_of_run = head_tok.last;

   always_comb begin
      head_in  = head_ff + QUEUE_AW'(pop);
      tail_in  = tail_ff;
      count_in = count_ff - QUEUE_CW'(pop);
      if (advance) begin
         tail_in  = tail_ff + QUEUE_AW'(tok_cnt);
         count_in = count_in + QUEUE_CW'(tok_cnt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) state_ff <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_ch_ff <= req_ch;
      if (advance && tok_cnt != 2'd0) q_ff[tail_ff] <= tok0;
      if (advance && tok_cnt == 2'd2) q_ff[tail_ff + QUEUE_AW'(1)] <= tok1;
   end

`ifndef SYNTHESIS
   // The queue never holds more tokens than it has slots.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("token queue overflow");

   // The end of source always yields at least the end token.
   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (advance && in_ch_ff == 8'd0) |-> (tok_cnt != 2'd0))
      else $error("end of source produced no token");

   // After the end of source the offset counter restarts from zero.
   a_end_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && in_ch_ff == 8'd0) |=> (state_ff.pos == '0 && state_ff.mode == MODE_IDLE))
      else $error("scanner did not restart after end of source");

   // An end token is always the last token of its character.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind == TK_END) |-> rsp_last_of_run)
      else $error("end token not marked last");
`endif

endmodule

FILE: test/c_like_lexical_scanner_unit_tb.sv
// Self-checking testbench for the C-like lexical scanner unit: feeds source bytes over the
// req_ channel and checks every token on the rsp_ channel against a scanner model in SV.
// Depends on hdl/clsu_pkg.sv, hdl/clsu_step.sv and hdl/c_like_lexical_scanner_unit.sv.
module c_like_lexical_scanner_unit_tb
   import clsu_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The block answers through its input register and token queue, so a short drain is plenty.
   localparam int DRAIN_CYCLES  = 16;
   // After this many tokens the receiver stops taking words for a long stretch, which
   // lets the token queue fill up and pushes back on the character input.
   localparam int HOLD_AT_TOKEN = 100;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_CHARS  = 820;

   typedef struct {
      logic [7:0] ch;
      bit         burst;
   } char_item_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_ch = 8'd0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [5:0]               rsp_token_kind;
   logic [OUT_POS_WIDTH-1:0] rsp_start_pos;
   logic [OUT_POS_WIDTH-1:0] rsp_end_pos;
   logic                     rsp_last_of_run;

   c_like_lexical_scanner_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_start_pos   (rsp_start_pos),
      .rsp_end_pos     (rsp_end_pos),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // Source text still to be sent, and the tokens that the accepted text must produce.
   char_item_type char_q [$];
   token_type     expected_tokens [$];

   int         chars_total   = 0;
   int         chars_sent    = 0;
   int         sources_ended = 0;
   int         tokens_seen   = 0;
   int         mismatches    = 0;
   bit [41:0]  kinds_seen    = '0;

   // ------------------------------------------------------------------------------------
   // Scanner model. It keeps its own copy of the scan state and, for every accepted
   // character, appends the tokens that character completes to expected_tokens.
   // ------------------------------------------------------------------------------------
   scan_mode_type          mode;
   logic [7:0]             pend_op;
   logic [POS_WIDTH-1:0]   tok_start;
   logic [POS_WIDTH-1:0]   cur_pos;
   logic [WORD_BITS-1:0]   word_bytes;
   logic [3:0]             word_len;
   int                     step_tokens;

   task automatic clear_scanner();
      mode       = MODE_IDLE;
      pend_op    = 8'd0;
      tok_start  = '0;
      cur_pos    = '0;
      word_bytes = '0;
      word_len   = 4'd0;
   endtask

   // Offsets stop at the all-ones value instead of wrapping.
   function automatic logic [POS_WIDTH-1:0] pos_next(input logic [POS_WIDTH-1:0] p);
      return (p == {POS_WIDTH{1'b1}}) ? p : p + 1'b1;
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   // Characters that might be the first half of a two-character lexeme or a comment.
   function automatic bit is_op_lead(input logic [7:0] c);
      return c == "!" || c == "+" || c == "-" || c == "=" || c == "&" ||
             c == "|" || c == "<" || c == ">" || c == "/";
   endfunction

   function automatic token_kind_type char_kind(input logic [7:0] c);
      token_kind_type k;
      k = TK_INVALID;
      if (c == "(") k = TK_LPAREN;
      if (c == ")") k = TK_RPAREN;
      if (c == "{") k = TK_LBRACE;
      if (c == "}") k = TK_RBRACE;
      if (c == "[") k = TK_LBRACK;
      if (c == "]") k = TK_RBRACK;
      if (c == ",") k = TK_COMMA;
      if (c == ";") k = TK_SEMI;
      if (c == "!") k = TK_NOT;
      if (c == "=") k = TK_ASSIGN;
      if (c == "+") k = TK_PLUS;
      if (c == "-") k = TK_MINUS;
      if (c == "*") k = TK_STAR;
      if (c == "/") k = TK_SLASH;
      if (c == "%") k = TK_PERCENT;
      if (c == "<") k = TK_LT;
      if (c == ">") k = TK_GT;
      return k;
   endfunction

   // No two-character lexeme is invalid, so TK_INVALID doubles as "no pair".
   function automatic token_kind_type pair_kind_of(input logic [7:0] a, input logic [7:0] b);
      token_kind_type k;
      k = TK_INVALID;
      if (a == b) begin
         if (a == "+") k = TK_INC;
         if (a == "-") k = TK_DEC;
         if (a == "&") k = TK_AND_AND;
         if (a == "|") k = TK_OR_OR;
         if (a == "=") k = TK_EQ;
      end else if (b == "=") begin
         if (a == "<") k = TK_LE;
         if (a == ">") k = TK_GE;
         if (a == "!") k = TK_NE;
      end
      return k;
   endfunction

   // Up to eight identifier bytes are nonzero and right-justified, so the packed value
   // alone tells both the text and its length.
   function automatic token_kind_type keyword_of(input logic [WORD_BITS-1:0] w,
                                                 input logic [3:0] len);
      token_kind_type k;
      k = TK_IDENT;
      if (len <= 4'd8) begin
         case (w)
            64'("if"):       k = TK_KW_IF;
            64'("else"):     k = TK_KW_ELSE;
            64'("for"):      k = TK_KW_FOR;
            64'("while"):    k = TK_KW_WHILE;
            64'("continue"): k = TK_KW_CONTINUE;
            64'("break"):    k = TK_KW_BREAK;
            64'("return"):   k = TK_KW_RETURN;
            64'("int"):      k = TK_KW_INT;
            64'("string"):   k = TK_KW_STRING;
            64'("void"):     k = TK_KW_VOID;
            64'("true"):     k = TK_KW_TRUE;
            64'("false"):    k = TK_KW_FALSE;
            default:         k = TK_IDENT;
         endcase
      end
      return k;
   endfunction

   task automatic add_token(input token_kind_type k, input logic [POS_WIDTH-1:0] s,
                            input logic [POS_WIDTH-1:0] e);
      token_type t;
      t.kind      = k;
      t.start_pos = OUT_POS_WIDTH'(s);
      t.end_pos   = OUT_POS_WIDTH'(e);
      t.last      = 1'b0;
      expected_tokens.insert(expected_tokens.size(), t);
      step_tokens++;
   endtask

   // A character seen between tokens either starts one, is skipped as whitespace, or is
   // a one-character token on its own (an invalid character included).
   task automatic open_token(input logic [7:0] c);
      mode = MODE_IDLE;
      if (!is_blank(c)) begin
         tok_start = cur_pos;
         if (is_digit(c)) begin
            mode = MODE_INT;
         end else if (is_letter(c) || c == "_") begin
            mode       = MODE_IDENT;
            word_bytes = WORD_BITS'(c);
            word_len   = 4'd1;
         end else if (c == "\"") begin
            mode = MODE_STR;
         end else if (is_op_lead(c)) begin
            mode    = MODE_OP;
            pend_op = c;
         end else begin
            add_token(char_kind(c), cur_pos, pos_next(cur_pos));
         end
      end
   endtask

   task automatic scan_char(input logic [7:0] c);
      token_kind_type k;
      token_type      t;
      step_tokens = 0;
      if (c == 8'd0) begin
         // End of source flushes the open token, if any, adds the end token, then starts over from zero.
         case (mode)
            MODE_INT:                add_token(TK_INT_LIT, tok_start, cur_pos);
            MODE_IDENT:              add_token(keyword_of(word_bytes, word_len), tok_start,
                                               cur_pos);
            MODE_STR, MODE_STR_ESC:  add_token(TK_STR_LIT, tok_start, cur_pos);
            MODE_OP:                 add_token(char_kind(pend_op), tok_start,
                                               pos_next(tok_start));
            default: ;
         endcase
         add_token(TK_END, cur_pos, cur_pos);
         clear_scanner();
      end else begin
         case (mode)
            MODE_LINE_CMT: begin
               if (c == "\n") mode = MODE_IDLE;
            end
            MODE_BLK_CMT: begin
               if (c == "*") mode = MODE_BLK_STAR;
            end
            MODE_BLK_STAR: begin
               if (c == "/") mode = MODE_IDLE;
               else if (c != "*") mode = MODE_BLK_CMT;
            end
            MODE_STR: begin
               if (c == "\"") begin
                  add_token(TK_STR_LIT, tok_start, pos_next(cur_pos));
                  mode = MODE_IDLE;
               end else if (c == "\\") begin
                  mode = MODE_STR_ESC;
               end
            end
            MODE_STR_ESC: begin
               mode = MODE_STR;
            end
            MODE_INT: begin
               if (!is_digit(c)) begin
                  add_token(TK_INT_LIT, tok_start, cur_pos);
                  open_token(c);
               end
            end
            MODE_IDENT: begin
               if (is_letter(c) || is_digit(c) || c == "_") begin
                  word_bytes = {word_bytes[WORD_BITS-9:0], c};
                  if (word_len != 4'd15) word_len = word_len + 4'd1;
               end else begin
                  add_token(keyword_of(word_bytes, word_len), tok_start, cur_pos);
                  open_token(c);
               end
            end
            MODE_OP: begin
               k = pair_kind_of(pend_op, c);
               if (pend_op == "/" && c == "/") begin
                  mode = MODE_LINE_CMT;
               end else if (pend_op == "/" && c == "*") begin
                  mode = MODE_BLK_CMT;
               end else if (k != TK_INVALID) begin
                  add_token(k, tok_start, pos_next(cur_pos));
                  mode = MODE_IDLE;
               end else begin
                  add_token(char_kind(pend_op), tok_start, pos_next(tok_start));
                  open_token(c);
               end
            end
            default: open_token(c);
         endcase
         cur_pos = pos_next(cur_pos);
      end
      // The last token that this character causes carries the end-of-run flag.
      if (step_tokens > 0) begin
         t      = expected_tokens.pop_back();
         t.last = 1'b1;
         expected_tokens.insert(expected_tokens.size(), t);
      end
   endtask

   // ------------------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------------------
   string keyword_text [12] = '{"if", "else", "for", "while", "continue", "break",
                                "return", "int", "string", "void", "true", "false"};
   string pair_text [8]     = '{"++", "--", "&&", "||", "<=", ">=", "==", "!="};
   string single_text       = "(){}[],;!=+-*/%<>&|";
   string blank_text        = " \t\n\r\v\f";
   string word_text         = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

   task automatic add_char(input logic [7:0] c, input bit burst);
      char_item_type it;
      it.ch    = c;
      it.burst = burst;
      char_q.insert(char_q.size(), it);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i], 1'b0);
   endtask

   task automatic add_blank();
      add_char(blank_text[$urandom_range(0, blank_text.len() - 1)], 1'b0);
   endtask

   // Each side draws a random wait per word, except during calm stretches, when it draws none.
   function automatic int unsigned idle_draw(input bit calm);
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   // ------------------------------------------------------------------------------------
   // Clock, reset and the main sequence.
   // ------------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      int          n;
      int          r;
      int          start_len;
      logic [7:0]  b;

      reset = 1'b1;
      clear_scanner();

      // Directed opening: the longest keyword glued to a pair operator and an integer,
      // a lone slash flushed by invalid high bytes, an unterminated string whose last
      // quote is escaped, an unterminated block comment, and a bar and an ampersand that form no pair.
      add_text("continue&&9/");
      add_char(8'hFF, 1'b0);
      add_char(8'h80, 1'b0);
      add_text("\"\\\"");
      add_char(8'd0, 1'b0);
      add_text("/*");
      add_char(8'd0, 1'b0);
      add_text("|&");
      add_char(8'd0, 1'b0);

      // Random source text: mostly well-formed lexemes with random content, with some
      // noise bytes, unterminated strings and early ends of source mixed in.
      start_len = char_q.size();
      while (char_q.size() - start_len < RANDOM_CHARS) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            add_text(keyword_text[$urandom_range(0, 11)]);
            if ($urandom_range(0, 3) == 0) add_char(word_text[$urandom_range(0, 62)], 1'b0);
         end else if (r < 30) begin
            // Mostly short names, some past the keyword length and the length counter.
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 18) : $urandom_range(1, 8);
            add_char(word_text[$urandom_range(0, 52)], 1'b0);
            for (int i = 1; i < n; i++) add_char(word_text[$urandom_range(0, 62)], 1'b0);
         end else if (r < 42) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) add_char(8'("0") + 8'($urandom_range(0, 9)), 1'b0);
         end else if (r < 52) begin
            add_char("\"", 1'b0);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
               b = 8'($urandom_range(1, 255));
               if (b == "\"" || b == "\\") begin
                  add_char("\\", 1'b0);
                  if (b == "\\") b = 8'($urandom_range(1, 255));
               end
               add_char(b, 1'b0);
            end
            if ($urandom_range(0, 7) != 0) add_char("\"", 1'b0);
         end else if (r < 62) begin
            add_char(single_text[$urandom_range(0, single_text.len() - 1)], 1'b0);
         end else if (r < 72) begin
            add_text(pair_text[$urandom_range(0, 7)]);
         end else if (r < 76) begin
            add_text("//");
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++) begin
               b = 8'($urandom_range(1, 255));
               add_char((b == "\n") ? 8'("x") : b, 1'b0);
            end
            add_char("\n", 1'b0);
         end else if (r < 80) begin
            add_text("/*");
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++) begin
               b = ($urandom_range(0, 3) == 0) ? 8'("*") : 8'($urandom_range(1, 255));
               add_char((b == "/") ? 8'("y") : b, 1'b0);
            end
            add_text("*/");
         end else if (r < 90) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) add_blank();
         end else if (r < 97) begin
            add_char(8'($urandom_range(1, 255)), 1'b0);
         end else begin
            add_char(8'd0, 1'b0);
         end
         // Half the lexemes are glued together, so one byte often ends two tokens.
         if ($urandom_range(0, 1) == 0) add_blank();
      end
      add_char(8'd0, 1'b0);
      chars_total = char_q.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (chars_sent != chars_total) @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Scanned %0d characters in %0d sources and checked %0d tokens,",
               chars_sent, sources_ended, tokens_seen);
      $display("covering %0d of the 42 token kinds, with %0d mismatches.",
               $countones(kinds_seen), mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // A hung handshake ends the run here.
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------------------
   // Driver. Each character word is predicted at the edge where it is accepted; valid
   // then either moves straight to the next word or drops for a random gap.
   // ------------------------------------------------------------------------------------
   int unsigned   send_gap  = 0;
   bit            send_calm = 1'b0;
   char_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_ch    <= 8'd0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            scan_char(req_ch);
            chars_sent++;
            if (req_ch == 8'd0) sources_ended++;
         end
         if (req_valid && !req_ready) begin
            // Hold the word until the block takes it.
         end else if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (char_q.size() != 0) begin
            next_item = char_q.pop_front();
            if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
            req_valid <= 1'b1;
            req_ch    <= next_item.ch;
            send_gap  <= next_item.burst ? 0 : idle_draw(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Monitor. Every token word taken is checked field by field against the oldest
   // expectation; ready then drops for a random stall, or once for a long hold-off.
   // ------------------------------------------------------------------------------------
   int  recv_stall = 0;
   bit  recv_calm  = 1'b0;
   token_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            tokens_seen++;
            if (rsp_token_kind < 6'd42) kinds_seen[rsp_token_kind] = 1'b1;
            if (expected_tokens.size() == 0) begin
               $error("unexpected token: kind %0d start %0d end %0d",
                      rsp_token_kind, rsp_start_pos, rsp_end_pos);
               mismatches++;
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_token_kind !== want.kind) begin
                  $error("token_kind: expected %0d, actual %0d", want.kind, rsp_token_kind);
                  mismatches++;
               end
               if (rsp_start_pos !== want.start_pos) begin
                  $error("start_pos: expected %0d, actual %0d", want.start_pos,
                         rsp_start_pos);
                  mismatches++;
               end
               if (rsp_end_pos !== want.end_pos) begin
                  $error("end_pos: expected %0d, actual %0d", want.end_pos, rsp_end_pos);
                  mismatches++;
               end
               if (rsp_last_of_run !== want.last) begin
                  $error("last_of_run: expected %0d, actual %0d", want.last,
                         rsp_last_of_run);
                  mismatches++;
               end
            end
            if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
            recv_stall = (tokens_seen == HOLD_AT_TOKEN) ? LONG_HOLD : idle_draw(recv_calm);
            rsp_ready <= (recv_stall == 0);
         end else if (recv_stall != 0) begin
            recv_stall = recv_stall - 1;
            rsp_ready <= (recv_stall == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

endmodule
